[rtl/vvc_pkg.sv]
// Shared types and codes for the varint / varlong codec.
// Used by the front end, the queue, the back end and the top level.
package vvc_pkg;

    // Result kinds on the output channel
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_SPACE = 2'd2;

    // Last byte index of a value in each mode
    localparam logic [3:0] LAST_IDX_32 = 4'd4;
    localparam logic [3:0] LAST_IDX_64 = 4'd9;

    // Work handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_VALUE  = 2'd0,
        OP_ERROR  = 2'd1,
        OP_ENCODE = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] data;   // decoded value or value to encode
        logic [3:0]  count;  // bytes used or bytes to emit
        logic [1:0]  err;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

endpackage

[rtl/vvc_front.sv]
// Front end: accepts items, runs the decode accumulator and sizes encodes.
// Pushes one work entry per result-bearing item into the queue; uses vvc_pkg.
module vvc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic               i_long_mode,
    input  logic [7:0]         i_in_byte,
    input  logic               i_buffer_end,
    input  logic signed [63:0] i_in_value,
    input  logic [3:0]         i_space_left,
    input  logic               i_full,
    output vvc_pkg::t_push     o_push
);

    logic [63:0] r_acc;
    logic [3:0]  r_byte_index;
    logic        r_value_mode;
    logic [63:0] n_acc;
    logic [3:0]  n_byte_index;
    logic        n_value_mode;

    logic        accept;
    logic        mode;
    logic [63:0] acc_base;
    logic [3:0]  last_idx;
    logic [3:0]  idx;
    logic [6:0]  shamt;
    logic [63:0] acc_new;
    logic        fin;
    logic [63:0] dec_value;
    logic [63:0] enc_u;
    logic [3:0]  enc_n;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    // Decode datapath
    always_comb begin
        mode     = (r_byte_index == 4'd0) ? i_long_mode : r_value_mode;
        acc_base = (r_byte_index == 4'd0) ? 64'd0 : r_acc;
        last_idx = mode ? vvc_pkg::LAST_IDX_64 : vvc_pkg::LAST_IDX_32;
        idx      = (r_byte_index > last_idx) ? last_idx : r_byte_index;
        shamt    = {idx, 3'b000} - {3'b000, idx};
        if (idx == last_idx) begin
            if (mode) begin
                acc_new = acc_base | {i_in_byte[0], 63'd0};
            end else begin
                acc_new = acc_base | {32'd0, i_in_byte[3:0], 28'd0};
            end
            fin = 1'b1;
        end else begin
            acc_new = acc_base | (64'(i_in_byte[6:0]) << shamt[5:0]);
            fin     = !i_in_byte[7];
        end
        dec_value = mode ? acc_new : {{32{acc_new[31]}}, acc_new[31:0]};
    end

    // Encode sizing: one byte per 7-bit group up to the highest nonzero one
    always_comb begin
        enc_u = i_long_mode ? $unsigned(i_in_value) : {32'd0, i_in_value[31:0]};
        enc_n = 4'd1;
        for (int k = 1; k < 10; k++) begin
            if ((enc_u >> (7 * k)) != 64'd0) begin
                enc_n = 4'(k + 1);
            end
        end
    end

    always_comb begin
        n_acc           = r_acc;
        n_byte_index    = r_byte_index;
        n_value_mode    = r_value_mode;
        o_push.valid    = 1'b0;
        o_push.entry.op = vvc_pkg::OP_VALUE;
        o_push.entry.data  = dec_value;
        o_push.entry.count = idx + 4'd1;
        o_push.entry.err   = vvc_pkg::ERR_NONE;
        if (accept) begin
            if (i_cmd) begin
                o_push.valid = 1'b1;
                if (i_space_left < enc_n) begin
                    o_push.entry.op    = vvc_pkg::OP_ERROR;
                    o_push.entry.data  = 64'd0;
                    o_push.entry.count = 4'd0;
                    o_push.entry.err   = vvc_pkg::ERR_SPACE;
                end else begin
                    o_push.entry.op    = vvc_pkg::OP_ENCODE;
                    o_push.entry.data  = enc_u;
                    o_push.entry.count = enc_n;
                end
            end else if (fin) begin
                o_push.valid = 1'b1;
                n_acc        = 64'd0;
                n_byte_index = 4'd0;
                n_value_mode = 1'b0;
            end else if (i_buffer_end) begin
                // out of input mid-value: report and drop the partial value
                o_push.valid       = 1'b1;
                o_push.entry.op    = vvc_pkg::OP_ERROR;
                o_push.entry.data  = 64'd0;
                o_push.entry.count = 4'd0;
                o_push.entry.err   = vvc_pkg::ERR_TRUNC;
                n_acc              = 64'd0;
                n_byte_index       = 4'd0;
                n_value_mode       = 1'b0;
            end else begin
                n_acc        = acc_new;
                n_byte_index = idx + 4'd1;
                n_value_mode = mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= 64'd0;
            r_byte_index <= 4'd0;
            r_value_mode <= 1'b0;
        end else begin
            r_acc        <= n_acc;
            r_byte_index <= n_byte_index;
            r_value_mode <= n_value_mode;
        end
    end

`ifndef SYNTH
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_value_mode ? (r_byte_index <= vvc_pkg::LAST_IDX_64)
                      : (r_byte_index <= vvc_pkg::LAST_IDX_32)))
        else $error("decode byte index beyond last byte of its mode");
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_index == 4'd0) |-> (r_acc == 64'd0 && !r_value_mode))
        else $error("decode state not cleared between values");
`endif

endmodule

[rtl/vvc_queue.sv]
// Short FIFO of work entries between the front end and the back end.
// Depth set by the top level; entry type from vvc_pkg.
module vvc_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vvc_pkg::t_push  i_push,
    output logic            o_full,
    output logic            o_q_valid,
    output vvc_pkg::t_entry o_entry,
    input  logic            i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    vvc_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_pop;

    assign o_full    = (r_count == CNT_FULL);
    assign o_q_valid = (r_count != '0);
    assign o_entry   = r_mem[r_rd_ptr];
    assign do_pop    = i_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push.valid && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && o_full))
        else $error("push into full work queue");
`endif

endmodule

[rtl/vvc_back.sv]
// Back end: drains work entries and drives the registered output channel.
// Serializes encodes one byte per cycle while i_stall is low; uses vvc_pkg.
module vvc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  vvc_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_kind,
    output logic [63:0]     o_value_out,
    output logic [7:0]      o_out_byte,
    output logic [3:0]      o_bytes_used,
    output logic [1:0]      o_error_code,
    output logic            o_last_of_run
);

    logic        r_valid, n_valid;
    logic [1:0]  r_kind, n_kind;
    logic [63:0] r_value, n_value;
    logic [7:0]  r_byte, n_byte;
    logic [3:0]  r_used, n_used;
    logic [1:0]  r_err, n_err;
    logic        r_last, n_last;
    logic        r_busy, n_busy;
    logic [63:0] r_shift, n_shift;
    logic [3:0]  r_left, n_left;
    logic        load;

    assign load = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        n_kind  = r_kind;
        n_value = r_value;
        n_byte  = r_byte;
        n_used  = r_used;
        n_err   = r_err;
        n_last  = r_last;
        n_busy  = r_busy;
        n_shift = r_shift;
        n_left  = r_left;
        o_pop   = 1'b0;
        if (load) begin
            if (r_busy) begin
                // next byte of a running encode
                n_valid = 1'b1;
                n_kind  = vvc_pkg::KIND_BYTE;
                n_value = 64'd0;
                n_used  = 4'd0;
                n_err   = vvc_pkg::ERR_NONE;
                n_last  = (r_left == 4'd1);
                n_byte  = {r_left != 4'd1, r_shift[6:0]};
                n_shift = r_shift >> 7;
                n_left  = r_left - 4'd1;
                n_busy  = (r_left != 4'd1);
            end else if (i_q_valid) begin
                o_pop   = 1'b1;
                n_valid = 1'b1;
                n_value = 64'd0;
                n_byte  = 8'd0;
                n_used  = 4'd0;
                n_err   = vvc_pkg::ERR_NONE;
                n_last  = 1'b1;
                unique case (i_entry.op)
                    vvc_pkg::OP_VALUE: begin
                        n_kind  = vvc_pkg::KIND_VALUE;
                        n_value = i_entry.data;
                        n_used  = i_entry.count;
                    end
                    vvc_pkg::OP_ENCODE: begin
                        n_kind  = vvc_pkg::KIND_BYTE;
                        n_last  = (i_entry.count == 4'd1);
                        n_byte  = {i_entry.count != 4'd1, i_entry.data[6:0]};
                        n_shift = i_entry.data >> 7;
                        n_left  = i_entry.count - 4'd1;
                        n_busy  = (i_entry.count != 4'd1);
                    end
                    default: begin
                        n_kind = vvc_pkg::KIND_ERROR;
                        n_err  = i_entry.err;
                    end
                endcase
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_left  <= 4'd0;
        end else begin
            r_valid <= n_valid;
            r_busy  <= n_busy;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_value <= n_value;
        r_byte  <= n_byte;
        r_used  <= n_used;
        r_err   <= n_err;
        r_last  <= n_last;
        r_shift <= n_shift;
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_value_out   = r_value;
    assign o_out_byte    = r_byte;
    assign o_bytes_used  = r_used;
    assign o_error_code  = r_err;
    assign o_last_of_run = r_last;

`ifndef SYNTH
    a_busy_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != 4'd0 && r_valid && !r_last))
        else $error("encode serializer busy with nothing left");
    a_cont_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == vvc_pkg::KIND_BYTE) |-> (r_byte[7] == !r_last))
        else $error("continuation bit does not match last byte");
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind != vvc_pkg::KIND_BYTE) |-> r_last)
        else $error("value or error result not marked last");
`endif

endmodule

[rtl/varint_varlong_codec.sv]
// Top level of the LEB128-style varint (32-bit) / varlong (64-bit) codec.
// Ties the front end, work queue and back end together; uses vvc_pkg.
//
// Input channel: i_valid / o_stall. An item is taken at a clock edge with
// i_valid high and o_stall low. Decode items (i_cmd 0) bring one byte each;
// encode items (i_cmd 1) bring one value plus the output space left.
// Output channel: o_valid / i_stall, one result per accepted transfer, with
// o_last_of_run marking the final result of an item.
// A result is registered in the work queue and then in the output register.
// Throughput: one decode byte per cycle while o_stall is low; an encode item
// occupies the back end's byte serializer until all of its emitted bytes
// (1 to 10) are out, while the front end keeps accepting into the work queue
// of QUEUE_DEPTH entries. o_stall rises only when that queue is full.
// Reset (synchronous, i_rst_n low) clears the decode accumulator, the queue
// and the output register. While i_stall is high the output item holds and
// work backs up into the queue, then onto o_stall.
module varint_varlong_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic               i_long_mode,
    input  logic [7:0]         i_in_byte,
    input  logic               i_buffer_end,
    input  logic signed [63:0] i_in_value,
    input  logic [3:0]         i_space_left,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [63:0] o_value_out,
    output logic [7:0]         o_out_byte,
    output logic [3:0]         o_bytes_used,
    output logic [1:0]         o_error_code,
    output logic               o_last_of_run
);

    vvc_pkg::t_push  push;
    vvc_pkg::t_entry entry;
    logic            full;
    logic            q_valid;
    logic            pop;
    logic [63:0]     value_out;

    vvc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_long_mode  (i_long_mode),
        .i_in_byte    (i_in_byte),
        .i_buffer_end (i_buffer_end),
        .i_in_value   (i_in_value),
        .i_space_left (i_space_left),
        .i_full       (full),
        .o_push       (push)
    );

    vvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .o_q_valid (q_valid),
        .o_entry   (entry),
        .i_pop     (pop)
    );

    vvc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_entry       (entry),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_value_out   (value_out),
        .o_out_byte    (o_out_byte),
        .o_bytes_used  (o_bytes_used),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

    assign o_value_out = $signed(value_out);

endmodule

[tb/varint_varlong_codec_test.sv]
// Self-checking testbench for the varint / varlong codec (varint_varlong_codec).
// Drives decode bytes and encode values, predicts every result and compares
// each field; depends on vvc_pkg and the codec RTL only.
`timescale 1ns / 1ps

module varint_varlong_codec_test;

    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;
    localparam logic MODE_32    = 1'b0;
    localparam logic MODE_64    = 1'b1;

    localparam int RANDOM_ITEMS = 150;
    localparam int CALM_ITEMS   = 30;
    localparam int END_CYCLES   = 20;
    // Longest correct quiet stretch is a few stall and gap bursts; allow far more.
    localparam int QUIET_LIMIT  = 1000;

    typedef struct {
        logic        cmd;
        logic        long_mode;
        logic [7:0]  in_byte;
        logic        buffer_end;
        logic [63:0] in_value;
        logic [3:0]  space_left;
        logic        drain_first;
    } t_codec_item;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] value;
        logic [7:0]  out_byte;
        logic [3:0]  used;
        logic [1:0]  err;
        logic        last;
    } t_codec_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_cmd = CMD_DECODE;
    logic               i_long_mode = MODE_32;
    logic [7:0]         i_in_byte = 8'd0;
    logic               i_buffer_end = 1'b0;
    logic signed [63:0] i_in_value = 64'sd0;
    logic [3:0]         i_space_left = 4'd0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_kind;
    logic signed [63:0] o_value_out;
    logic [7:0]         o_out_byte;
    logic [3:0]         o_bytes_used;
    logic [1:0]         o_error_code;
    logic               o_last_of_run;

    t_codec_item   items_to_send[$];
    t_codec_result results_due[$];
    t_codec_item   presented;

    // Decode state of the predictor
    logic [63:0] acc_bits = 64'd0;
    int          bytes_seen = 0;
    logic        value_is_long = MODE_32;

    int  total_items = 0;
    int  items_accepted = 0;
    int  decodes_sent = 0;
    int  encodes_sent = 0;
    int  results_checked = 0;
    int  values_decoded = 0;
    int  bytes_emitted = 0;
    int  trunc_errors = 0;
    int  space_errors = 0;
    int  fail_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    logic calm = 1'b0;
    logic idle_phase = 1'b1;

    varint_varlong_codec i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_long_mode   (i_long_mode),
        .i_in_byte     (i_in_byte),
        .i_buffer_end  (i_buffer_end),
        .i_in_value    (i_in_value),
        .i_space_left  (i_space_left),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_value_out   (o_value_out),
        .o_out_byte    (o_out_byte),
        .o_bytes_used  (o_bytes_used),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void push_result(logic [1:0] kind, logic [63:0] value,
                                        logic [7:0] out_byte, logic [3:0] used,
                                        logic [1:0] err, logic last);
        t_codec_result r;
        r.kind     = kind;
        r.value    = value;
        r.out_byte = out_byte;
        r.used     = used;
        r.err      = err;
        r.last     = last;
        results_due.push_back(r);
    endfunction

    function automatic void clear_decode_state();
        acc_bits      = 64'd0;
        bytes_seen    = 0;
        value_is_long = MODE_32;
    endfunction

    // Work out the results of one accepted item and advance the decode state.
    function automatic void predict_codec(t_codec_item item);
        logic [63:0] u;
        logic [63:0] t;
        logic [63:0] decoded;
        int          n;
        int          idx;
        int          last_idx;
        logic        done;
        if (item.cmd == CMD_ENCODE) begin
            u = item.long_mode ? item.in_value : {32'd0, item.in_value[31:0]};
            n = 1;
            t = u;
            while (t > 64'h7f) begin
                t = t >> 7;
                n++;
            end
            if (int'(item.space_left) < n) begin
                push_result(vvc_pkg::KIND_ERROR, 64'd0, 8'd0, 4'd0, vvc_pkg::ERR_SPACE,
                            1'b1);
            end else begin
                for (int k = 0; k < n; k++) begin
                    push_result(vvc_pkg::KIND_BYTE, 64'd0, {k != n - 1, u[6:0]}, 4'd0,
                                vvc_pkg::ERR_NONE, k == n - 1);
                    u = u >> 7;
                end
            end
        end else begin
            if (bytes_seen == 0) begin
                value_is_long = item.long_mode;
                acc_bits      = 64'd0;
            end
            last_idx = value_is_long ? int'(vvc_pkg::LAST_IDX_64)
                                     : int'(vvc_pkg::LAST_IDX_32);
            idx      = (bytes_seen > last_idx) ? last_idx : bytes_seen;
            if (idx == last_idx) begin
                if (value_is_long)
                    acc_bits[63] = acc_bits[63] | item.in_byte[0];
                else
                    acc_bits[31:28] = acc_bits[31:28] | item.in_byte[3:0];
                done = 1'b1;
            end else begin
                acc_bits = acc_bits | ({57'd0, item.in_byte[6:0]} << (7 * idx));
                done     = !item.in_byte[7];
            end
            if (done) begin
                decoded = value_is_long ? acc_bits : {{32{acc_bits[31]}}, acc_bits[31:0]};
                push_result(vvc_pkg::KIND_VALUE, decoded, 8'd0, 4'(idx + 1),
                            vvc_pkg::ERR_NONE, 1'b1);
                clear_decode_state();
            end else if (item.buffer_end) begin
                push_result(vvc_pkg::KIND_ERROR, 64'd0, 8'd0, 4'd0, vvc_pkg::ERR_TRUNC,
                            1'b1);
                clear_decode_state();
            end else begin
                bytes_seen = idx + 1;
            end
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void queue_decode(logic mode, logic [7:0] b, logic end_flag);
        t_codec_item item;
        item.cmd         = CMD_DECODE;
        item.long_mode   = mode;
        item.in_byte     = b;
        item.buffer_end  = end_flag;
        item.in_value    = {$urandom, $urandom};
        item.space_left  = 4'($urandom_range(0, 15));
        item.drain_first = 1'b0;
        items_to_send.push_back(item);
    endfunction

    function automatic void queue_encode(logic mode, logic [63:0] v, logic [3:0] space,
                                         logic drain);
        t_codec_item item;
        item.cmd         = CMD_ENCODE;
        item.long_mode   = mode;
        item.in_byte     = 8'($urandom_range(0, 255));
        item.buffer_end  = 1'($urandom_range(0, 1));
        item.in_value    = v;
        item.space_left  = space;
        item.drain_first = drain;
        items_to_send.push_back(item);
    endfunction

    // Send a value as a decode sequence, optionally with padding groups;
    // junk goes into the ignored bits of a full-length final byte.
    function automatic void queue_well_formed(logic mode, logic [63:0] v, int pad);
        logic [63:0] u;
        logic [7:0]  b;
        int          last_idx;
        int          n;
        u        = mode ? v : {32'd0, v[31:0]};
        last_idx = mode ? int'(vvc_pkg::LAST_IDX_64) : int'(vvc_pkg::LAST_IDX_32);
        n = 1;
        while (n <= last_idx && (u >> (7 * n)) != 64'd0)
            n++;
        n = n + pad;
        if (n > last_idx + 1)
            n = last_idx + 1;
        for (int k = 0; k < n; k++) begin
            if (k == last_idx) begin
                b = 8'($urandom_range(0, 255));
                if (mode)
                    b[0] = u[63];
                else
                    b[3:0] = u[31:28];
            end else begin
                b[6:0] = u[7 * k +: 7];
                b[7]   = (k != n - 1);
            end
            queue_decode(k == 0 ? mode : 1'($urandom_range(0, 1)), b,
                         k == n - 1 ? 1'($urandom_range(0, 1)) : 1'b0);
        end
    endfunction

    function automatic void queue_truncated(logic mode, int len);
        for (int k = 0; k < len; k++)
            queue_decode(k == 0 ? mode : 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)) | 8'h80, k == len - 1);
    endfunction

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 3) == 0)
            v = -v;
        return v;
    endfunction

    // Driver: present the next pending item whenever the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_codec(presented);
                items_accepted++;
                if (presented.cmd == CMD_ENCODE)
                    encodes_sent++;
                else
                    decodes_sent++;
            end
            calm       <= (items_accepted + CALM_ITEMS >= total_items);
            idle_phase <= (items_accepted % 48) < 32;
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    i_valid <= 1'b0;
                    gap_left--;
                end else if (items_to_send.size() != 0 &&
                             (!items_to_send[0].drain_first ||
                              (results_due.size() == 0 && !o_valid))) begin
                    presented = items_to_send.pop_front();
                    i_cmd        <= presented.cmd;
                    i_long_mode  <= presented.long_mode;
                    i_in_byte    <= presented.in_byte;
                    i_buffer_end <= presented.buffer_end;
                    i_in_value   <= presented.in_value;
                    i_space_left <= presented.space_left;
                    i_valid      <= 1'b1;
                    if (idle_phase && !calm && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 4);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result against the oldest expectation.
    always @(posedge i_clk) begin
        t_codec_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (results_due.size() == 0) begin
                    $error("unexpected result: kind %0d", o_kind);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("value_out", want.value, o_value_out);
                    check_field("out_byte", want.out_byte, o_out_byte);
                    check_field("bytes_used", want.used, o_bytes_used);
                    check_field("error_code", want.err, o_error_code);
                    check_field("last_of_run", want.last, o_last_of_run);
                    results_checked++;
                    if (want.kind == vvc_pkg::KIND_VALUE)
                        values_decoded++;
                    else if (want.kind == vvc_pkg::KIND_BYTE)
                        bytes_emitted++;
                    else if (want.err == vvc_pkg::ERR_TRUNC)
                        trunc_errors++;
                    else
                        space_errors++;
                end
            end
            if (stall_left != 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                if (!calm && (results_checked % 40) < 28 && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 4);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: %0d cycles without a transfer", quiet_cycles);
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int   pick;
        logic m;
        int   trunc_max;
        // Directed part: single-byte extremes
        queue_decode(MODE_32, 8'h00, 1'b1);
        queue_decode(MODE_32, 8'h7f, 1'b0);
        // Full-length 32-bit value, final byte with its top bit set and buffer end
        for (int k = 0; k < 5; k++)
            queue_decode(MODE_32, 8'hff, k == 4);
        // 64-bit value whose later bytes claim 32-bit mode
        queue_decode(MODE_64, 8'h80, 1'b0);
        for (int k = 0; k < 8; k++)
            queue_decode(MODE_32, 8'h80, 1'b0);
        queue_decode(MODE_32, 8'h01, 1'b0);
        // Continuation byte at buffer end
        queue_decode(MODE_32, 8'h80, 1'b1);
        // Encode in the middle of a partial decode; hold until drained first
        queue_decode(MODE_32, 8'h81, 1'b0);
        queue_encode(MODE_64, 64'h7fffffffffffffff, 4'd10, 1'b1);
        queue_decode(MODE_32, 8'h01, 1'b1);
        queue_encode(MODE_64, 64'hffffffffffffffff, 4'd10, 1'b0);
        queue_encode(MODE_32, 64'hffffffff80000000, 4'd5, 1'b0);
        queue_encode(MODE_32, 64'd0, 4'd0, 1'b0);
        queue_encode(MODE_64, 64'hffffffffffffffff, 4'd9, 1'b0);
        queue_encode(MODE_32, 64'd0, 4'd15, 1'b0);

        total_items = items_to_send.size() + RANDOM_ITEMS;
        while (items_to_send.size() < total_items) begin
            pick = $urandom_range(0, 19);
            m    = 1'($urandom_range(0, 1));
            trunc_max = m ? int'(vvc_pkg::LAST_IDX_64) : int'(vvc_pkg::LAST_IDX_32);
            if (pick < 8)
                queue_well_formed(m, rand_value(),
                                  $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
            else if (pick < 10)
                queue_truncated(m, $urandom_range(1, trunc_max));
            else if (pick < 18)
                queue_encode(m, rand_value(),
                             $urandom_range(0, 3) == 0 ? 4'($urandom_range(0, 15)) : 4'd10,
                             $urandom_range(0, 29) == 0);
            else
                queue_decode(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        total_items = items_to_send.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_accepted != total_items)
            @(negedge i_clk);
        while (results_due.size() != 0 || o_valid)
            @(negedge i_clk);
        repeat (END_CYCLES) @(negedge i_clk);

        $display("covered %0d decode bytes and %0d encode items", decodes_sent, encodes_sent);
        $display("checked %0d values, %0d bytes, %0d truncations, %0d space errors",
                 values_decoded, bytes_emitted, trunc_errors, space_errors);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
